@@ design/lcdnw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types, constants and microcode for the LCD nibble writer
// Holds the control word layout, request codes and the sequencer program.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

   localparam int PcWidth      = 6;
   localparam int HoldWidth    = 16;
   localparam int CsrIdxWidth  = 2;

   // request codes on req_type
   typedef enum logic [2:0] {
      REQ_INIT    = 3'd0,
      REQ_NIBBLE  = 3'd1,
      REQ_CMDBYTE = 3'd2,
      REQ_DATA    = 3'd3,
      REQ_CURSOR  = 3'd4
   } req_code_type;

   // configuration register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CHAR_DELAY = 2'd0,
      CSR_POWER_WAIT = 2'd1,
      CSR_CURSOR_DLY = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      NIB_CONST = 2'd0,
      NIB_HI    = 2'd1,
      NIB_LO    = 2'd2
   } nib_sel_type;

   typedef enum logic [2:0] {
      HOLD_ONE   = 3'd0,
      HOLD_ZERO  = 3'd1,
      HOLD_53    = 3'd2,
      HOLD_100   = 3'd3,
      HOLD_3000  = 3'd4,
      HOLD_4100  = 3'd5,
      HOLD_POWER = 3'd6,
      HOLD_EXEC  = 3'd7
   } hold_sel_type;

   typedef struct packed {
      logic         en;
      nib_sel_type  nib_sel;
      logic [3:0]   nib_const;
      hold_sel_type hold_sel;
      logic         last;
   } ctrl_word_type;

   // program entry points
   localparam logic [PcWidth-1:0] PC_INIT   = 6'd0;
   localparam logic [PcWidth-1:0] PC_NIBBLE = 6'd29;
   localparam logic [PcWidth-1:0] PC_BYTE   = 6'd31;

   localparam logic [HoldWidth-1:0] Hold53   = 16'd53;
   localparam logic [HoldWidth-1:0] Hold100  = 16'd100;
   localparam logic [HoldWidth-1:0] Hold3000 = 16'd3000;
   localparam logic [HoldWidth-1:0] Hold4100 = 16'd4100;

   localparam logic [HoldWidth-1:0] CharDelayRst  = 16'd53;
   localparam logic [HoldWidth-1:0] PowerWaitRst  = 16'd50000;
   localparam logic [HoldWidth-1:0] CursorDlyRst  = 16'd53;

   localparam logic [7:0] CursorCmdBase = 8'h80;

   function automatic ctrl_word_type mk(input logic en, input nib_sel_type sel,
                                        input logic [3:0] nib,
                                        input hold_sel_type hold,
                                        input logic last);
      ctrl_word_type w;
      w.en        = en;
      w.nib_sel   = sel;
      w.nib_const = nib;
      w.hold_sel  = hold;
      w.last      = last;
      return w;
   endfunction

   // microcode ROM: one pin segment per step
   function automatic ctrl_word_type rom(input logic [PcWidth-1:0] pc);
      ctrl_word_type w;
      w = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b1);
      unique case (pc)
         // power-on wait, then the three wake-up nibbles and the 4-bit switch
         6'd0:  w = mk(1'b0, NIB_CONST, 4'h0, HOLD_POWER, 1'b0);
         6'd1:  w = mk(1'b1, NIB_CONST, 4'h3, HOLD_ONE,   1'b0);
         6'd2:  w = mk(1'b0, NIB_CONST, 4'h3, HOLD_4100,  1'b0);
         6'd3:  w = mk(1'b1, NIB_CONST, 4'h3, HOLD_ONE,   1'b0);
         6'd4:  w = mk(1'b0, NIB_CONST, 4'h3, HOLD_100,   1'b0);
         6'd5:  w = mk(1'b1, NIB_CONST, 4'h3, HOLD_ONE,   1'b0);
         6'd6:  w = mk(1'b0, NIB_CONST, 4'h3, HOLD_100,   1'b0);
         6'd7:  w = mk(1'b1, NIB_CONST, 4'h2, HOLD_ONE,   1'b0);
         6'd8:  w = mk(1'b0, NIB_CONST, 4'h2, HOLD_100,   1'b0);
         // function set 0x28
         6'd9:  w = mk(1'b1, NIB_CONST, 4'h2, HOLD_ONE,   1'b0);
         6'd10: w = mk(1'b0, NIB_CONST, 4'h2, HOLD_ZERO,  1'b0);
         6'd11: w = mk(1'b1, NIB_CONST, 4'h8, HOLD_ONE,   1'b0);
         6'd12: w = mk(1'b0, NIB_CONST, 4'h8, HOLD_53,    1'b0);
         // display off 0x08
         6'd13: w = mk(1'b1, NIB_CONST, 4'h0, HOLD_ONE,   1'b0);
         6'd14: w = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO,  1'b0);
         6'd15: w = mk(1'b1, NIB_CONST, 4'h8, HOLD_ONE,   1'b0);
         6'd16: w = mk(1'b0, NIB_CONST, 4'h8, HOLD_53,    1'b0);
         // clear 0x01
         6'd17: w = mk(1'b1, NIB_CONST, 4'h0, HOLD_ONE,   1'b0);
         6'd18: w = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO,  1'b0);
         6'd19: w = mk(1'b1, NIB_CONST, 4'h1, HOLD_ONE,   1'b0);
         6'd20: w = mk(1'b0, NIB_CONST, 4'h1, HOLD_3000,  1'b0);
         // entry mode 0x06
         6'd21: w = mk(1'b1, NIB_CONST, 4'h0, HOLD_ONE,   1'b0);
         6'd22: w = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO,  1'b0);
         6'd23: w = mk(1'b1, NIB_CONST, 4'h6, HOLD_ONE,   1'b0);
         6'd24: w = mk(1'b0, NIB_CONST, 4'h6, HOLD_53,    1'b0);
         // display on 0x0C
         6'd25: w = mk(1'b1, NIB_CONST, 4'h0, HOLD_ONE,   1'b0);
         6'd26: w = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO,  1'b0);
         6'd27: w = mk(1'b1, NIB_CONST, 4'hC, HOLD_ONE,   1'b0);
         6'd28: w = mk(1'b0, NIB_CONST, 4'hC, HOLD_53,    1'b1);
         // single nibble from the low bits of the operand
         6'd29: w = mk(1'b1, NIB_LO,    4'h0, HOLD_ONE,   1'b0);
         6'd30: w = mk(1'b0, NIB_LO,    4'h0, HOLD_EXEC,  1'b1);
         // full byte, high nibble first
         6'd31: w = mk(1'b1, NIB_HI,    4'h0, HOLD_ONE,   1'b0);
         6'd32: w = mk(1'b0, NIB_HI,    4'h0, HOLD_ZERO,  1'b0);
         6'd33: w = mk(1'b1, NIB_LO,    4'h0, HOLD_ONE,   1'b0);
         6'd34: w = mk(1'b0, NIB_LO,    4'h0, HOLD_EXEC,  1'b1);
         default: w = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b1);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ design/char_lcd_nibble_write_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top: 4-bit character LCD write sequencer
// Expands one request into a list of pin segments from a microcode ROM.
// ----------------------------------------------------------------------------
// An accepted request loads the step counter; its first segment is then registered.
// Throughput: one segment per cycle while rsp_ready is high, set by the single
// step counter walking the ROM; req_ready stays low until the request's last
// segment is registered: 29 segments for init, 2 for a nibble, 4 for a byte.
// Request types 5..7 are accepted and dropped. Reset empties the output
// register and loads the delay registers with their defaults.
`default_nettype none

module char_lcd_nibble_write_sequencer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_value,
   input  wire logic [15:0] req_delay_us,
   input  wire logic        req_row,
   input  wire logic [5:0]  req_column,
   // segment channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_rs,
   output logic             rsp_enable,
   output logic [3:0]       rsp_nibble,
   output logic [15:0]      rsp_hold_us,
   output logic             rsp_last
);

   logic [15:0] char_delay_ff, power_wait_ff, cursor_dly_ff;

   logic                                  busy_ff, busy_in;
   logic [lcdnw_pkg::PcWidth-1:0]         pc_ff, pc_in;
   logic                                  rs_ff, rs_in;
   logic [7:0]                            operand_ff, operand_in;
   logic [15:0]                           exec_ff, exec_in;

   logic                                  valid_ff, valid_in;
   logic                                  out_rs_ff, out_rs_in;
   logic                                  out_en_ff, out_en_in;
   logic [3:0]                            out_nib_ff, out_nib_in;
   logic [15:0]                           out_hold_ff, out_hold_in;
   logic                                  out_last_ff, out_last_in;

   lcdnw_pkg::ctrl_word_type              cw;
   lcdnw_pkg::req_code_type               code;
   logic                                  accept, step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         char_delay_ff <= lcdnw_pkg::CharDelayRst;
         power_wait_ff <= lcdnw_pkg::PowerWaitRst;
         cursor_dly_ff <= lcdnw_pkg::CursorDlyRst;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lcdnw_pkg::CSR_CHAR_DELAY: char_delay_ff <= csr_data;
            lcdnw_pkg::CSR_POWER_WAIT: power_wait_ff <= csr_data;
            lcdnw_pkg::CSR_CURSOR_DLY: cursor_dly_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign code      = lcdnw_pkg::req_code_type'(req_type);
   assign cw        = lcdnw_pkg::rom(pc_ff);
   assign step      = busy_ff && (!valid_ff || rsp_ready);

   always_comb begin
      busy_in     = busy_ff;
      pc_in       = pc_ff;
      rs_in       = rs_ff;
      operand_in  = operand_ff;
      exec_in     = exec_ff;
      valid_in    = valid_ff;
      out_rs_in   = out_rs_ff;
      out_en_in   = out_en_ff;
      out_nib_in  = out_nib_ff;
      out_hold_in = out_hold_ff;
      out_last_in = out_last_ff;

      // drop a taken segment
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end

      if (step) begin
         valid_in  = 1'b1;
         out_rs_in = rs_ff;
         out_en_in = cw.en;
         unique case (cw.nib_sel)
            lcdnw_pkg::NIB_HI:    out_nib_in = operand_ff[7:4];
            lcdnw_pkg::NIB_LO:    out_nib_in = operand_ff[3:0];
            default:              out_nib_in = cw.nib_const;
         endcase
         unique case (cw.hold_sel)
            lcdnw_pkg::HOLD_ONE:   out_hold_in = 16'd1;
            lcdnw_pkg::HOLD_ZERO:  out_hold_in = 16'd0;
            lcdnw_pkg::HOLD_53:    out_hold_in = lcdnw_pkg::Hold53;
            lcdnw_pkg::HOLD_100:   out_hold_in = lcdnw_pkg::Hold100;
            lcdnw_pkg::HOLD_3000:  out_hold_in = lcdnw_pkg::Hold3000;
            lcdnw_pkg::HOLD_4100:  out_hold_in = lcdnw_pkg::Hold4100;
            lcdnw_pkg::HOLD_POWER: out_hold_in = power_wait_ff;
            default:               out_hold_in = exec_ff;
         endcase
         out_last_in = cw.last;
         pc_in       = pc_ff + 1'b1;
         if (cw.last) begin
            busy_in = 1'b0;
         end
      end

      if (accept) begin
         operand_in = req_value;
         exec_in    = req_delay_us;
         rs_in      = 1'b0;
         busy_in    = 1'b1;
         unique case (code)
            lcdnw_pkg::REQ_INIT: begin
               pc_in = lcdnw_pkg::PC_INIT;
            end
            lcdnw_pkg::REQ_NIBBLE: begin
               pc_in = lcdnw_pkg::PC_NIBBLE;
            end
            lcdnw_pkg::REQ_CMDBYTE: begin
               pc_in = lcdnw_pkg::PC_BYTE;
            end
            lcdnw_pkg::REQ_DATA: begin
               pc_in   = lcdnw_pkg::PC_BYTE;
               rs_in   = 1'b1;
               exec_in = char_delay_ff;
            end
            lcdnw_pkg::REQ_CURSOR: begin
               pc_in      = lcdnw_pkg::PC_BYTE;
               exec_in    = cursor_dly_ff;
               operand_in = lcdnw_pkg::CursorCmdBase | {1'b0, req_row, 6'd0}
                            | {2'b00, req_column};
            end
            default: begin
               // unused request code: no segments
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         pc_ff    <= lcdnw_pkg::PC_INIT;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         pc_ff    <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      rs_ff       <= rs_in;
      operand_ff  <= operand_in;
      exec_ff     <= exec_in;
      out_rs_ff   <= out_rs_in;
      out_en_ff   <= out_en_in;
      out_nib_ff  <= out_nib_in;
      out_hold_ff <= out_hold_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_rs      = out_rs_ff;
   assign rsp_enable  = out_en_ff;
   assign rsp_nibble  = out_nib_ff;
   assign rsp_hold_us = out_hold_ff;
   assign rsp_last    = out_last_ff;

endmodule

`default_nettype wire
